// ----- rtl/dgi_pkg.sv -----
// Shared types, codes and arithmetic helpers for the deformation gradient increment block.
`default_nettype none

package dgi_pkg;

    // Start value selected by the first item of a run.
    localparam logic OP_IDENT = 1'b0;
    localparam logic OP_ZERO  = 1'b1;

    localparam int unsigned VEC_LEN = 3;
    localparam int unsigned MAT_LEN = 9;

    typedef logic [VEC_LEN-1:0][31:0] vec3_t;
    typedef logic [MAT_LEN-1:0][63:0] mat64_t;
    typedef logic [MAT_LEN-1:0][31:0] mat32_t;

    // Control that travels with an item through the pipeline.
    typedef struct packed {
        logic valid;
        logic opcode;
        logic last;
    } item_ctl_t;

    // Signed 64-bit addition that clamps to the signed range on overflow.
    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63]))
        begin
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dgi_mult.sv -----
// Input register and product register: forms the nine outer-product terms of one node.
`default_nettype none

module dgi_mult #(
    parameter int NDIM = 3
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 in_opcode,
    input  wire                 in_last,
    input  wire dgi_pkg::vec3_t in_u,
    input  wire dgi_pkg::vec3_t in_g,
    input  wire                 prod_ready,
    output dgi_pkg::item_ctl_t  prod_ctl,
    output dgi_pkg::mat64_t     prod
);

    localparam int ND = (NDIM < 3) ? 2 : 3;

    dgi_pkg::item_ctl_t s1_ctl_reg;
    dgi_pkg::vec3_t     s1_u_reg;
    dgi_pkg::vec3_t     s1_g_reg;
    dgi_pkg::item_ctl_t s2_ctl_reg;
    dgi_pkg::mat64_t    prod_reg;
    dgi_pkg::mat64_t    prod_next;
    logic               adv1;
    logic               adv2;

    assign adv2     = !s2_ctl_reg.valid || prod_ready;
    assign adv1     = !s1_ctl_reg.valid || adv2;
    assign in_ready = adv1;

    // Terms outside the active dimensions stay zero.
    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            if ((i < ND) && (j < ND))
            begin : g_live
                logic signed [63:0] p;
                assign p = $signed(s1_u_reg[i]) * $signed(s1_g_reg[j]);
                assign prod_next[i*3+j] = p;
            end
            else
            begin : g_dead
                assign prod_next[i*3+j] = 64'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            if (adv1)
            begin
                s1_ctl_reg <= '{valid: in_valid, opcode: in_opcode, last: in_last};
            end
            if (adv2)
            begin
                s2_ctl_reg <= s1_ctl_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_u_reg <= in_u;
            s1_g_reg <= in_g;
        end
        if (adv2 && s1_ctl_reg.valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_ctl = s2_ctl_reg;
    assign prod     = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/dgi_acc.sv -----
// Run accumulator: adds each node's products into the tensor and hands off the closed sum.
`default_nettype none

module dgi_acc #(
    parameter int NDIM      = 3,
    parameter int FRAC_BITS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire dgi_pkg::item_ctl_t prod_ctl,
    input  wire dgi_pkg::mat64_t    prod,
    output logic                prod_ready,
    output logic                res_valid,
    input  wire                 res_ready,
    output dgi_pkg::mat64_t     res_sum
);

    localparam int          ND      = (NDIM < 3) ? 2 : 3;
    localparam logic [63:0] ONE_ACC = 64'd1 << (2 * FRAC_BITS);

    dgi_pkg::mat64_t acc_reg;
    dgi_pkg::mat64_t res_reg;
    dgi_pkg::mat64_t sum_next;
    logic            run_open_reg;
    logic            res_valid_reg;
    logic            consume;

    // A non-final item only touches the accumulator, so it never waits.
    assign consume    = prod_ctl.valid &&
                        (!prod_ctl.last || !res_valid_reg || res_ready);
    assign prod_ready = consume;

    for (genvar k = 0; k < 9; k++)
    begin : g_elem
        logic [63:0] base;
        always_comb
        begin
            if (run_open_reg)
            begin
                base = acc_reg[k];
            end
            else if ((prod_ctl.opcode == dgi_pkg::OP_IDENT) && ((k % 4) == 0) && ((k / 4) < ND))
            begin
                base = ONE_ACC;
            end
            else
            begin
                base = 64'd0;
            end
        end
        assign sum_next[k] = dgi_pkg::sat_add64(base, prod[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (consume)
            begin
                run_open_reg <= !prod_ctl.last;
            end
            if (!res_valid_reg || res_ready)
            begin
                res_valid_reg <= consume && prod_ctl.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            acc_reg <= sum_next;
        end
        if (consume && prod_ctl.last)
        begin
            res_reg <= sum_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_sum   = res_reg;

endmodule

`default_nettype wire

// ----- rtl/dgi_round.sv -----
// Output register: rounds the closed sum to the input format and saturates it to 32 bits.
`default_nettype none

module dgi_round #(
    parameter int FRAC_BITS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 res_valid,
    output logic                res_ready,
    input  wire dgi_pkg::mat64_t res_sum,
    output logic                out_valid,
    input  wire                 out_ready,
    output dgi_pkg::mat32_t     out_mat
);

    localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [64:0] QMAX = 65'sd2147483647;
    localparam logic signed [64:0] QMIN = -65'sd2147483648;

    dgi_pkg::mat32_t out_reg;
    dgi_pkg::mat32_t out_next;
    logic            out_valid_reg;

    assign res_ready = !out_valid_reg || out_ready;

    // Round to nearest with ties toward plus infinity, then clamp.
    for (genvar k = 0; k < 9; k++)
    begin : g_elem
        logic signed [64:0] biased;
        logic signed [64:0] q;
        assign biased = $signed({res_sum[k][63], res_sum[k]}) + HALF;
        assign q      = biased >>> FRAC_BITS;
        always_comb
        begin
            if (q > QMAX)
            begin
                out_next[k] = 32'h7fff_ffff;
            end
            else if (q < QMIN)
            begin
                out_next[k] = 32'h8000_0000;
            end
            else
            begin
                out_next[k] = q[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mat   = out_reg;

endmodule

`default_nettype wire

// ----- rtl/deformation_gradient_increment.sv -----
// Top level of the deformation gradient increment block: outer-product accumulation per particle.
// A final node word is registered in the input register, the product register, the holding
// register and the output register in turn, then shows its tensor on m_tdata with m_tvalid high.
// Throughput: one node word per cycle unless the output stalls; the nine multiplies work in
// parallel and the accumulator sum feeds straight back, so runs of any length stream without gaps.
// Reset (rst_n low, asynchronous) empties every pipeline stage and closes any open run.
`default_nettype none

module deformation_gradient_increment #(
    parameter int NDIM      = 3,
    parameter int FRAC_BITS = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    // Node words in.
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [191:0] s_tdata,   // incr_x, incr_y, incr_z, grad_x, grad_y, grad_z (32 bits each)
    input  wire          s_tuser,   // opcode
    input  wire          s_tlast,   // last_node
    // Tensor words out.
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [287:0] m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (32 bits each)
);

    dgi_pkg::vec3_t     in_u;
    dgi_pkg::vec3_t     in_g;
    dgi_pkg::item_ctl_t prod_ctl;
    dgi_pkg::mat64_t    prod;
    dgi_pkg::mat64_t    res_sum;
    dgi_pkg::mat32_t    out_mat;
    logic               prod_ready;
    logic               res_valid;
    logic               res_ready;

    // Unpack the node word: increments first, then gradients.
    assign in_u = s_tdata[95:0];
    assign in_g = s_tdata[191:96];

    // Stage one registers the node, stage two registers the nine products.
    dgi_mult #(
        .NDIM (NDIM)
    ) u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_opcode  (s_tuser),
        .in_last    (s_tlast),
        .in_u       (in_u),
        .in_g       (in_g),
        .prod_ready (prod_ready),
        .prod_ctl   (prod_ctl),
        .prod       (prod)
    );

    // The accumulator picks its start value on the first node of a run and hands
    // the closed sum to a holding register on the final node.
    dgi_acc #(
        .NDIM      (NDIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_ctl   (prod_ctl),
        .prod       (prod),
        .prod_ready (prod_ready),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_sum    (res_sum)
    );

    // The output register rounds and saturates; while it waits for the sink the stages in front
    // keep taking node words until a final node finds the holding register still full.
    dgi_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_sum   (res_sum),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mat   (out_mat)
    );

    assign m_tdata = out_mat;

    // A node that does not close its run never waits in the accumulator.
    a_nonlast_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_ctl.valid && !prod_ctl.last) |-> prod_ready)
        else $error("non-final node stalled in accumulator");

    // The input side is open whenever the product stage is empty.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !prod_ctl.valid |-> s_tready)
        else $error("input blocked with empty pipeline");

    // A closed sum that the output register cannot take is kept.
    a_sum_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("closed sum lost while output stalled");

    // A tensor word appears only from a closed sum.
    a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(res_valid))
        else $error("tensor word without a closed run");

endmodule

`default_nettype wire
